// File: hdl/bis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image scaler package
// Sizes, register codes and the structs that run between the pipeline parts.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;
  localparam int STEP_FRAC  = 16;

  localparam int COORD_W = 8;
  localparam int DIM_W   = 9;
  localparam int STEP_W  = 24;
  localparam int DST_W   = 10;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int PIX_W   = NUM_CH * CH_W;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = STEP_W;

  localparam int POS_W   = DST_W + STEP_W;
  localparam int INT_W   = POS_W - STEP_FRAC;
  localparam int XI_W    = $clog2(MAX_WIDTH);
  localparam int YI_W    = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int BANK_W  = ADDR_W - 1;
  localparam int BANK_DEPTH = 2 ** BANK_W;

  localparam int NBR     = 4;
  localparam int WT_W    = 2 * FRAC_BITS + 1;
  localparam int PROD_W  = CH_W + WT_W;
  localparam int SUM_W   = PROD_W + 2;

  localparam logic [FRAC_BITS:0]   SCALE    = (FRAC_BITS + 1)'(1 << FRAC_BITS);
  localparam logic [WT_W+1:0]      WT_TOTAL = (WT_W + 2)'(1 << (2 * FRAC_BITS));
  localparam logic [STEP_W-1:0]    STEP_ONE = STEP_W'(1 << STEP_FRAC);
  localparam logic [DIM_W-1:0]     DIM_MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0]     DIM_MAX_H = DIM_W'(MAX_HEIGHT);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 4'd0,
    CFG_SRC_HEIGHT = 4'd1,
    CFG_X_STEP     = 4'd2,
    CFG_Y_STEP     = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
  } bis_geom_t;

  // Front end to pixel store: bank reads, bank write, weights
  typedef struct packed {
    logic                      op;
    logic                      wr_en;
    logic                      wr_bank;
    logic [BANK_W-1:0]         wr_idx;
    logic [PIX_W-1:0]          wr_data;
    logic [BANK_W-1:0]         ev_top;
    logic [BANK_W-1:0]         od_top;
    logic [BANK_W-1:0]         ev_bot;
    logic [BANK_W-1:0]         od_bot;
    logic                      swap_top;
    logic                      swap_bot;
    logic [NBR-1:0]            mask;
    logic [NBR-1:0][WT_W-1:0]  wt;
    logic [DST_W-1:0]          dst_x;
    logic [DST_W-1:0]          dst_y;
  } bis_req_t;

  // Pixel store to blend: the four neighbours in corner order
  typedef struct packed {
    logic [NBR-1:0][PIX_W-1:0] pix;
    logic [NBR-1:0]            mask;
    logic [NBR-1:0][WT_W-1:0]  wt;
    logic [DST_W-1:0]          dst_x;
    logic [DST_W-1:0]          dst_y;
  } bis_nbr_t;

endpackage

// File: hdl/bis_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear scaler front end
// Three stages: step multiply, neighbour address and bounds, bank indexes
// and corner weights. Write items get their linear address here too.
// ----------------------------------------------------------------------------
module bis_front
  import bis_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  bis_geom_t          geom,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [COORD_W-1:0] src_x,
  input  logic [COORD_W-1:0] src_y,
  input  logic [CH_W-1:0]    red,
  input  logic [CH_W-1:0]    green,
  input  logic [CH_W-1:0]    blue,
  input  logic [DST_W-1:0]   dst_x,
  input  logic [DST_W-1:0]   dst_y,
  output logic               req_valid,
  input  logic               req_stall,
  output bis_req_t           req
);

  // stage 1
  logic                      v1;
  logic                      op1;
  logic [POS_W-1:0]          px1;
  logic [POS_W-1:0]          py1;
  logic                      wr_en1;
  logic [ADDR_W-1:0]         waddr1;
  logic [PIX_W-1:0]          wdata1;
  logic [DST_W-1:0]          dx1;
  logic [DST_W-1:0]          dy1;
  // stage 2
  logic                      v2;
  logic                      op2;
  logic                      wr_en2;
  logic [ADDR_W-1:0]         waddr2;
  logic [PIX_W-1:0]          wdata2;
  logic [ADDR_W-1:0]         a2;
  logic [NBR-1:0]            mask2;
  logic [FRAC_BITS-1:0]      u2;
  logic [FRAC_BITS-1:0]      fv2;
  logic [DST_W-1:0]          dx2;
  logic [DST_W-1:0]          dy2;
  // stage 3
  logic                      v3;
  bis_req_t                  r3;

  logic hold1, hold2, hold3;
  logic load1, load2, load3;

  assign hold3 = v3 && req_stall;
  assign hold2 = v2 && hold3;
  assign hold1 = v1 && hold2;
  assign load1 = in_valid && !hold1;
  assign load2 = v1 && !hold2;
  assign load3 = v2 && !hold3;
  assign in_stall  = hold1;
  assign req_valid = v3;
  assign req       = r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= hold1 ? 1'b1 : in_valid;
      v2 <= hold2 ? 1'b1 : v1;
      v3 <= hold3 ? 1'b1 : v2;
    end
  end

  // stage 1: source position and write address
  logic [POS_W-1:0]         px_c;
  logic [POS_W-1:0]         py_c;
  logic [COORD_W+DIM_W-1:0] wrow_c;
  logic [COORD_W+DIM_W-1:0] wlin_c;
  logic                     wok_c;

  assign px_c   = POS_W'(dst_x) * POS_W'(geom.x_step);
  assign py_c   = POS_W'(dst_y) * POS_W'(geom.y_step);
  assign wrow_c = (COORD_W + DIM_W)'(src_y) * (COORD_W + DIM_W)'(geom.w);
  assign wlin_c = wrow_c + (COORD_W + DIM_W)'(src_x);
  assign wok_c  = (op == OP_WRITE) && ({1'b0, src_x} < geom.w) && ({1'b0, src_y} < geom.h);

  always_ff @(posedge clk) begin
    if (load1) begin
      op1    <= op;
      px1    <= px_c;
      py1    <= py_c;
      wr_en1 <= wok_c;
      waddr1 <= wlin_c[ADDR_W-1:0];
      wdata1 <= {red, green, blue};
      dx1    <= dst_x;
      dy1    <= dst_y;
    end
  end

  // stage 2: integer part, fraction, bounds and top-left address
  logic [INT_W-1:0]       ix_c;
  logic [INT_W-1:0]       iy_c;
  logic [INT_W:0]         ix1_c;
  logic [INT_W:0]         iy1_c;
  logic                   vx0_c, vx1_c, vy0_c, vy1_c;
  logic [YI_W+DIM_W-1:0]  arow_c;
  logic [YI_W+DIM_W-1:0]  alin_c;

  assign ix_c   = px1[POS_W-1:STEP_FRAC];
  assign iy_c   = py1[POS_W-1:STEP_FRAC];
  assign ix1_c  = {1'b0, ix_c} + 1'b1;
  assign iy1_c  = {1'b0, iy_c} + 1'b1;
  assign vx0_c  = ix_c < INT_W'(geom.w);
  assign vx1_c  = ix1_c < (INT_W + 1)'(geom.w);
  assign vy0_c  = iy_c < INT_W'(geom.h);
  assign vy1_c  = iy1_c < (INT_W + 1)'(geom.h);
  assign arow_c = (YI_W + DIM_W)'(iy_c[YI_W-1:0]) * (YI_W + DIM_W)'(geom.w);
  assign alin_c = arow_c + (YI_W + DIM_W)'(ix_c[XI_W-1:0]);

  always_ff @(posedge clk) begin
    if (load2) begin
      op2    <= op1;
      wr_en2 <= wr_en1;
      waddr2 <= waddr1;
      wdata2 <= wdata1;
      a2     <= alin_c[ADDR_W-1:0];
      mask2  <= {vx1_c && vy1_c, vx0_c && vy1_c, vx1_c && vy0_c, vx0_c && vy0_c};
      u2     <= px1[STEP_FRAC-1 -: FRAC_BITS];
      fv2    <= py1[STEP_FRAC-1 -: FRAC_BITS];
      dx2    <= dx1;
      dy2    <= dy1;
    end
  end

  // stage 3: bank indexes for the even/odd split, corner weights
  logic [ADDR_W-1:0]      b_c;
  logic [ADDR_W:0]        a_inc_c;
  logic [ADDR_W:0]        b_inc_c;
  logic [FRAC_BITS:0]     su_c;
  logic [FRAC_BITS:0]     sv_c;
  logic [2*FRAC_BITS+1:0] w0_c, w1_c, w2_c, w3_c;

  assign b_c     = a2 + ADDR_W'(geom.w);
  assign a_inc_c = {1'b0, a2} + 1'b1;
  assign b_inc_c = {1'b0, b_c} + 1'b1;
  assign su_c    = SCALE - {1'b0, u2};
  assign sv_c    = SCALE - {1'b0, fv2};
  assign w0_c    = (2 * FRAC_BITS + 2)'(su_c) * (2 * FRAC_BITS + 2)'(sv_c);
  assign w1_c    = (2 * FRAC_BITS + 2)'(u2) * (2 * FRAC_BITS + 2)'(sv_c);
  assign w2_c    = (2 * FRAC_BITS + 2)'(su_c) * (2 * FRAC_BITS + 2)'(fv2);
  assign w3_c    = (2 * FRAC_BITS + 2)'(u2) * (2 * FRAC_BITS + 2)'(fv2);

  always_ff @(posedge clk) begin
    if (load3) begin
      r3.op       <= op2;
      r3.wr_en    <= wr_en2;
      r3.wr_bank  <= waddr2[0];
      r3.wr_idx   <= waddr2[ADDR_W-1:1];
      r3.wr_data  <= wdata2;
      r3.ev_top   <= a_inc_c[BANK_W:1];
      r3.od_top   <= a2[ADDR_W-1:1];
      r3.ev_bot   <= b_inc_c[BANK_W:1];
      r3.od_bot   <= b_c[ADDR_W-1:1];
      r3.swap_top <= a2[0];
      r3.swap_bot <= b_c[0];
      r3.mask     <= mask2;
      r3.wt[0]    <= w0_c[WT_W-1:0];
      r3.wt[1]    <= w1_c[WT_W-1:0];
      r3.wt[2]    <= w2_c[WT_W-1:0];
      r3.wt[3]    <= w3_c[WT_W-1:0];
      r3.dst_x    <= dx2;
      r3.dst_y    <= dy2;
    end
  end

  // a right or lower neighbour inside the image implies the one it leans on
  a_mask_right : assert property (@(posedge clk) disable iff (rst)
    (v2 && mask2[1]) |-> mask2[0])
    else $error("right neighbour in bounds while top-left is not");

  a_mask_lower : assert property (@(posedge clk) disable iff (rst)
    (v2 && mask2[3]) |-> (mask2[1] && mask2[2]))
    else $error("lower-right neighbour in bounds while an adjacent one is not");

endmodule

// File: hdl/bis_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear scaler pixel store
// Source pixels split into even and odd linear addresses; each bank takes
// one write and two reads per cycle, so all four neighbours come in one go.
// ----------------------------------------------------------------------------
module bis_store
  import bis_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  bis_req_t req,
  output logic     nbr_valid,
  input  logic     nbr_stall,
  output bis_nbr_t nbr
);

  logic [PIX_W-1:0] even_mem [BANK_DEPTH];
  logic [PIX_W-1:0] odd_mem  [BANK_DEPTH];

  logic             v4;
  logic             op4;
  logic             swap_top4;
  logic             swap_bot4;
  logic [PIX_W-1:0] ev_top4;
  logic [PIX_W-1:0] od_top4;
  logic [PIX_W-1:0] ev_bot4;
  logic [PIX_W-1:0] od_bot4;
  logic [NBR-1:0]           mask4;
  logic [NBR-1:0][WT_W-1:0] wt4;
  logic [DST_W-1:0] dx4;
  logic [DST_W-1:0] dy4;

  logic hold4;
  logic load4;

  // write items end here; only reads move on
  assign nbr_valid = v4 && (op4 == OP_READ);
  assign hold4     = nbr_valid && nbr_stall;
  assign load4     = req_valid && !hold4;
  assign req_stall = hold4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= hold4 ? 1'b1 : req_valid;
    end
  end

  // reads and writes share the load edge, so item order is kept
  always_ff @(posedge clk) begin
    if (load4) begin
      if (req.wr_en && !req.wr_bank) begin
        even_mem[req.wr_idx] <= req.wr_data;
      end
      if (req.wr_en && req.wr_bank) begin
        odd_mem[req.wr_idx] <= req.wr_data;
      end
      ev_top4 <= even_mem[req.ev_top];
      ev_bot4 <= even_mem[req.ev_bot];
      od_top4 <= odd_mem[req.od_top];
      od_bot4 <= odd_mem[req.od_bot];
    end
  end

  always_ff @(posedge clk) begin
    if (load4) begin
      op4       <= req.op;
      swap_top4 <= req.swap_top;
      swap_bot4 <= req.swap_bot;
      mask4     <= req.mask;
      wt4       <= req.wt;
      dx4       <= req.dst_x;
      dy4       <= req.dst_y;
    end
  end

  // odd base address: left pixel sits in the odd bank
  assign nbr.pix[0] = swap_top4 ? od_top4 : ev_top4;
  assign nbr.pix[1] = swap_top4 ? ev_top4 : od_top4;
  assign nbr.pix[2] = swap_bot4 ? od_bot4 : ev_bot4;
  assign nbr.pix[3] = swap_bot4 ? ev_bot4 : od_bot4;
  assign nbr.mask   = mask4;
  assign nbr.wt     = wt4;
  assign nbr.dst_x  = dx4;
  assign nbr.dst_y  = dy4;

endmodule

// File: hdl/bis_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear scaler blend
// Weighted products per channel and corner, then the four-way sum,
// truncated to the channel width in the output register.
// ----------------------------------------------------------------------------
module bis_blend
  import bis_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              nbr_valid,
  output logic              nbr_stall,
  input  bis_nbr_t          nbr,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CH_W-1:0]   out_red,
  output logic [CH_W-1:0]   out_green,
  output logic [CH_W-1:0]   out_blue,
  output logic [DST_W-1:0]  out_dst_x,
  output logic [DST_W-1:0]  out_dst_y
);

  logic                                v5;
  logic [NUM_CH-1:0][NBR-1:0][PROD_W-1:0] prod5;
  logic [DST_W-1:0]                    dx5;
  logic [DST_W-1:0]                    dy5;
  logic                                v6;

  logic hold5, hold6;
  logic load5, load6;

  assign hold6     = v6 && out_stall;
  assign hold5     = v5 && hold6;
  assign load5     = nbr_valid && !hold5;
  assign load6     = v5 && !hold6;
  assign nbr_stall = hold5;
  assign out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v5 <= hold5 ? 1'b1 : nbr_valid;
      v6 <= hold6 ? 1'b1 : v5;
    end
  end

  // stage 5: products, neighbours outside the image give zero
  logic [NUM_CH-1:0][NBR-1:0][PROD_W-1:0] prod_c;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int n = 0; n < NBR; n++) begin
        prod_c[ch][n] = nbr.mask[n]
          ? PROD_W'(nbr.pix[n][PIX_W-1-ch*CH_W -: CH_W]) * PROD_W'(nbr.wt[n])
          : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load5) begin
      prod5 <= prod_c;
      dx5   <= nbr.dst_x;
      dy5   <= nbr.dst_y;
    end
  end

  // stage 6: sum and truncate
  logic [NUM_CH-1:0][SUM_W-1:0] sum_c;
  logic                         sum_high_c;

  always_comb begin
    sum_high_c = 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_c[ch] = SUM_W'(prod5[ch][0]) + SUM_W'(prod5[ch][1])
                + SUM_W'(prod5[ch][2]) + SUM_W'(prod5[ch][3]);
      sum_high_c = sum_high_c || (|sum_c[ch][SUM_W-1:2*FRAC_BITS+CH_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (load6) begin
      out_red   <= sum_c[0][2*FRAC_BITS +: CH_W];
      out_green <= sum_c[1][2*FRAC_BITS +: CH_W];
      out_blue  <= sum_c[2][2*FRAC_BITS +: CH_W];
      out_dst_x <= dx5;
      out_dst_y <= dy5;
    end
  end

  logic [WT_W+1:0] wt_sum_c;
  assign wt_sum_c = (WT_W + 2)'(nbr.wt[0]) + (WT_W + 2)'(nbr.wt[1])
                  + (WT_W + 2)'(nbr.wt[2]) + (WT_W + 2)'(nbr.wt[3]);

  a_weight_total : assert property (@(posedge clk) disable iff (rst)
    nbr_valid |-> (wt_sum_c == WT_TOTAL))
    else $error("corner weights do not add up to full scale");

  a_sum_range : assert property (@(posedge clk) disable iff (rst)
    v5 |-> !sum_high_c)
    else $error("blended sum exceeds channel range");

  a_out_follows : assert property (@(posedge clk) disable iff (rst)
    (v5 && !hold6) |=> v6)
    else $error("blended item lost between sum and output register");

endmodule

// File: hdl/bilinear_image_scaler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bilinear image scaler unit
// Loads RGB source pixels and returns bilinear blends at scaled positions.
// ----------------------------------------------------------------------------
// One item enters per clock while in_stall is low. A read result passes
// through six register stages (three front-end stages, the store read,
// product and sum stages) before it can transfer out; write items finish at
// the store stage and return nothing. The store is split into even and odd
// linear addresses, each bank serving two reads and one write per cycle, so
// all four neighbours come out together. The store has no clearing pass: a
// pixel read before it was written returns garbage. Program the registers
// only while no item is in flight. cfg_ready is always high.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_unit
  import bis_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [COORD_W-1:0]    src_x,
  input  logic [COORD_W-1:0]    src_y,
  input  logic [CH_W-1:0]       red,
  input  logic [CH_W-1:0]       green,
  input  logic [CH_W-1:0]       blue,
  input  logic [DST_W-1:0]      dst_x,
  input  logic [DST_W-1:0]      dst_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CH_W-1:0]       out_red,
  output logic [CH_W-1:0]       out_green,
  output logic [CH_W-1:0]       out_blue,
  output logic [DST_W-1:0]      out_dst_x,
  output logic [DST_W-1:0]      out_dst_y
);

  logic [DIM_W-1:0]  src_width;
  logic [DIM_W-1:0]  src_height;
  logic [STEP_W-1:0] x_step;
  logic [STEP_W-1:0] y_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_MAX_W;
      src_height <= DIM_MAX_H;
      x_step     <= STEP_ONE;
      y_step     <= STEP_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SRC_WIDTH:  src_width  <= cfg_data[DIM_W-1:0];
        CFG_SRC_HEIGHT: src_height <= cfg_data[DIM_W-1:0];
        CFG_X_STEP:     x_step     <= cfg_data[STEP_W-1:0];
        CFG_Y_STEP:     y_step     <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the image size to the store
  bis_geom_t geom;
  assign geom.w      = (src_width > DIM_MAX_W) ? DIM_MAX_W : src_width;
  assign geom.h      = (src_height > DIM_MAX_H) ? DIM_MAX_H : src_height;
  assign geom.x_step = x_step;
  assign geom.y_step = y_step;

  logic     req_valid;
  logic     req_stall;
  bis_req_t req;
  logic     nbr_valid;
  logic     nbr_stall;
  bis_nbr_t nbr;

  bis_front u_front (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .src_x     (src_x),
    .src_y     (src_y),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .dst_x     (dst_x),
    .dst_y     (dst_y),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req)
  );

  bis_store u_store (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .nbr_valid (nbr_valid),
    .nbr_stall (nbr_stall),
    .nbr       (nbr)
  );

  bis_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .nbr_valid (nbr_valid),
    .nbr_stall (nbr_stall),
    .nbr       (nbr),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_dst_x (out_dst_x),
    .out_dst_y (out_dst_y)
  );

endmodule
